[design/assert_macros.svh]
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked only outside reset
`define BSD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked only outside reset
`define BSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication checked at every edge, reset included
`define BSD_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/bsd_pkg.sv]
// shared types, constants and bayer slot tables for the demosaic block
package bsd_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int DIM_W   = 13;
  localparam int RAW_W   = 16;
  localparam int PIX_W   = 8;
  localparam int POS_W   = 12;
  localparam int CFG_AW  = 3;
  localparam int NUM_W   = 20;
  localparam int DEN_W   = 12;
  localparam int QDEPTH  = 4;

  localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_BAYER_PATTERN = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SAMPLE_FORMAT = 3'd3;
  localparam logic [CFG_AW-1:0] REG_STRETCH_LOW   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_STRETCH_HIGH  = 3'd5;

  localparam logic [1:0] KIND_FOUR   = 2'd0;
  localparam logic [1:0] KIND_PAIR_V = 2'd1;
  localparam logic [1:0] KIND_PAIR_H = 2'd2;
  localparam logic [1:0] KIND_ONE    = 2'd3;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [1:0]       bayer_pattern;
    logic             sample_format;
    logic [PIX_W-1:0] stretch_low;
    logic [PIX_W-1:0] stretch_high;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [1:0]       kind;
    logic             frame_end;
  } job_t;

  function automatic logic [1:0] red_slot(input logic [1:0] p);
    logic [1:0] s;
    case (p)
      2'd0:    s = 2'd1;
      2'd1:    s = 2'd0;
      2'd2:    s = 2'd2;
      default: s = 2'd3;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] grn1_slot(input logic [1:0] p);
    return p[0] ? 2'd1 : 2'd0;
  endfunction

  function automatic logic [1:0] grn2_slot(input logic [1:0] p);
    return p[0] ? 2'd2 : 2'd3;
  endfunction

  function automatic logic [1:0] blu_slot(input logic [1:0] p);
    logic [1:0] s;
    case (p)
      2'd0:    s = 2'd2;
      2'd1:    s = 2'd3;
      2'd2:    s = 2'd1;
      default: s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

[design/bsd_div.sv]
// restoring divider, one quotient bit per cycle
module bsd_div
  import bsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] n_r, n_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_r, n_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W - 1);
      n_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      n_nxt   = {n_r[NUM_W-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = n_r;

endmodule

[design/bsd_front.sv]
// front end: sample conversion and contrast stretch, line and block stores, block colour and job build
module bsd_front
  import bsd_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [RAW_W-1:0] in_raw,
  output logic             job_valid,
  input  logic             job_ready,
  output job_t             job,
  output logic             div_start,
  output logic [NUM_W-1:0] div_num,
  output logic [DEN_W-1:0] div_den,
  input  logic             div_done,
  input  logic [NUM_W-1:0] div_quo
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int BD = (MAX_WIDTH + 1) / 2;
  localparam int BW = (BD > 1) ? $clog2(BD) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_STR  = 3'd3;
  localparam logic [2:0] ST_DIVB = 3'd4;
  localparam logic [2:0] ST_RD0  = 3'd5;
  localparam logic [2:0] ST_RD1  = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     c_r, c_nxt;
  logic [RW-1:0]     r_r, r_nxt;
  logic [RAW_W-1:0]  raw_r, raw_nxt;
  logic [PIX_W-1:0]  v_r, v_nxt;
  logic [PIX_W-1:0]  up0_r, up0_nxt;
  logic [PIX_W-1:0]  left_r, left_nxt;
  logic [23:0]       last_col_r, last_col_nxt;

  logic [PIX_W-1:0]  upper_mem [MAX_WIDTH];
  logic [23:0]       block_mem [BD];
  logic [PIX_W-1:0]  upper_q_r;
  logic [23:0]       block_q_r;
  logic [CW-1:0]     upper_raddr;
  logic [BW-1:0]     block_addr;
  logic              upper_we, block_we;
  logic [23:0]       colour;

  logic [31:0]       w32, h32, fw32, fh32, c32, r32, col32, row32;
  logic              wrap;
  logic              row_odd, col_odd, last_col, last_row;
  logic [PIX_W-1:0]  blk [4];
  logic [PIX_W-1:0]  red_v, grn_v, blu_v;
  logic [PIX_W:0]    gsum;
  logic [NUM_W-1:0]  conv_num;
  logic [NUM_W:0]    conv_sum;
  logic [PIX_W-1:0]  conv_v;

  assign fw32 = 32'(cfg.frame_width);
  assign fh32 = 32'(cfg.frame_height);
  assign w32  = (fw32 < 32'd2) ? 32'd2 : (fw32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : fw32;
  assign h32  = (fh32 < 32'd2) ? 32'd2 : (fh32 > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : fh32;
  assign col32 = 32'(col_r);
  assign row32 = 32'(row_r);
  assign wrap  = (col32 >= w32) || (row32 >= h32);
  assign c32   = 32'(c_r);
  assign r32   = 32'(r_r);

  assign row_odd  = r_r[0];
  assign col_odd  = c_r[0];
  assign last_col = (c32 == w32 - 32'd1);
  assign last_row = (r32 == h32 - 32'd1);

  // twelve-bit reduction, x / 4095 as (x + (x >> 12) + 1) >> 12, exact for x below 2^24 - 1
  assign conv_num = NUM_W'(20'(raw_r[11:0]) * 20'd255 + 20'd2047);
  assign conv_sum = (NUM_W+1)'(conv_num) + (NUM_W+1)'(conv_num >> 12) + (NUM_W+1)'(1);
  assign conv_v   = conv_sum[12 +: PIX_W];

  assign blk[0] = up0_r;
  assign blk[1] = upper_q_r;
  assign blk[2] = left_r;
  assign blk[3] = v_r;
  assign red_v  = blk[red_slot(cfg.bayer_pattern)];
  assign gsum   = {1'b0, blk[grn1_slot(cfg.bayer_pattern)]}
                + {1'b0, blk[grn2_slot(cfg.bayer_pattern)]} + 1'b1;
  assign grn_v  = gsum[PIX_W:1];
  assign blu_v  = blk[blu_slot(cfg.bayer_pattern)];
  assign colour = {red_v, grn_v, blu_v};

  assign upper_raddr = (state_r == ST_RD0) ? CW'(c_r - 1'b1) : c_r;
  assign block_addr  = BW'(CW'(c_r - 1'b1) >> 1);
  assign upper_we    = (state_r == ST_EMIT) && job_ready && !row_odd && !last_row;
  assign block_we    = (state_r == ST_EMIT) && job_ready && row_odd && col_odd;

  always_ff @(posedge clk) begin
    if (upper_we) begin
      upper_mem[c_r] <= v_r;
    end
    upper_q_r <= upper_mem[upper_raddr];
  end

  always_ff @(posedge clk) begin
    if (block_we) begin
      block_mem[BW'(c_r >> 1)] <= colour;
    end
    block_q_r <= block_mem[block_addr];
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    c_nxt        = c_r;
    r_nxt        = r_r;
    raw_nxt      = raw_r;
    v_nxt        = v_r;
    up0_nxt      = up0_r;
    left_nxt     = left_r;
    last_col_nxt = last_col_r;
    div_start    = 1'b0;
    div_num      = '0;
    div_den      = '0;
    job_valid    = 1'b0;
    job          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          raw_nxt   = in_raw;
          c_nxt     = wrap ? '0 : col_r;
          r_nxt     = wrap ? '0 : row_r;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (cfg.sample_format) begin
          v_nxt = conv_v;
        end else begin
          v_nxt = raw_r[PIX_W-1:0];
        end
        state_nxt = ST_STR;
      end
      ST_STR: begin
        state_nxt = ST_RD0;
        if (cfg.stretch_high > cfg.stretch_low) begin
          if (v_r <= cfg.stretch_low) begin
            v_nxt = '0;
          end else begin
            div_start = 1'b1;
            div_num   = NUM_W'({8'd0, v_r - cfg.stretch_low} * 16'd255);
            div_den   = DEN_W'(cfg.stretch_high - cfg.stretch_low);
            state_nxt = ST_DIVB;
          end
        end
      end
      ST_DIVB: begin
        if (div_done) begin
          v_nxt     = (div_quo > NUM_W'(255)) ? 8'hFF : div_quo[PIX_W-1:0];
          state_nxt = ST_RD0;
        end
      end
      ST_RD0: begin
        state_nxt = ST_RD1;
      end
      ST_RD1: begin
        up0_nxt   = upper_q_r;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        job.row       = POS_W'(r_r);
        job.col       = POS_W'(c_r);
        job.frame_end = last_row && last_col;
        if (row_odd) begin
          if (col_odd) begin
            job_valid = 1'b1;
            job.kind  = KIND_FOUR;
            {job.red, job.green, job.blue} = colour;
          end else if (last_col) begin
            job_valid = 1'b1;
            job.kind  = KIND_PAIR_V;
            {job.red, job.green, job.blue} = last_col_r;
          end
        end else if (last_row) begin
          if (col_odd) begin
            job_valid = 1'b1;
            job.kind  = KIND_PAIR_H;
            {job.red, job.green, job.blue} = block_q_r;
          end else if (last_col) begin
            job_valid = 1'b1;
            job.kind  = KIND_ONE;
            {job.red, job.green, job.blue} = block_q_r;
          end
        end
        if (job_ready) begin
          if (row_odd && col_odd) begin
            last_col_nxt = colour;
          end
          if (row_odd && !col_odd) begin
            left_nxt = v_r;
          end
          if (c32 + 32'd1 >= w32) begin
            col_nxt = '0;
            row_nxt = (r32 + 32'd1 >= h32) ? '0 : RW'(r_r + 1'b1);
          end else begin
            col_nxt = CW'(c_r + 1'b1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      col_r      <= '0;
      row_r      <= '0;
      left_r     <= '0;
      last_col_r <= '0;
    end else begin
      state_r    <= state_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      left_r     <= left_nxt;
      last_col_r <= last_col_nxt;
    end
    c_r   <= c_nxt;
    r_r   <= r_nxt;
    raw_r <= raw_nxt;
    v_r   <= v_nxt;
    up0_r <= up0_nxt;
  end

endmodule

[design/bsd_queue.sv]
// short job queue between front and back
module bsd_queue
  import bsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  localparam int AW = $clog2(QDEPTH);

  job_t          slots [QDEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != (AW+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = slots[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = do_push ? AW'(wp_r + 1'b1) : wp_r;
    rp_nxt  = do_pop ? AW'(rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      slots[wp_r] <= push_job;
    end
  end

endmodule

[design/bsd_back.sv]
// back end: expands each job into its output pixel words
module bsd_back
  import bsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_data,
  output logic        out_last,
  output logic        out_fend
);

  job_t             cur_r, cur_nxt;
  logic             busy_r, busy_nxt;
  logic [1:0]       k_r, k_nxt;
  logic             ov_r, ov_nxt;
  logic [47:0]      od_r, od_nxt;
  logic             ol_r, ol_nxt;
  logic             of_r, of_nxt;
  logic             adv;
  logic [1:0]       k_last;
  logic [POS_W-1:0] wc, wr, cm1, rm1;

  assign adv       = !ov_r || out_ready;
  assign job_ready = !busy_r;
  assign cm1       = cur_r.col - 1'b1;
  assign rm1       = cur_r.row - 1'b1;

  always_comb begin
    k_last = 2'd0;
    wc     = cur_r.col;
    wr     = cur_r.row;
    case (cur_r.kind)
      KIND_FOUR: begin
        k_last = 2'd3;
        wc     = k_r[0] ? cur_r.col : cm1;
        wr     = k_r[1] ? cur_r.row : rm1;
      end
      KIND_PAIR_V: begin
        k_last = 2'd1;
        wr     = k_r[0] ? cur_r.row : rm1;
      end
      KIND_PAIR_H: begin
        k_last = 2'd1;
        wc     = k_r[0] ? cur_r.col : cm1;
      end
      default: k_last = 2'd0;
    endcase
  end

  always_comb begin
    cur_nxt  = cur_r;
    busy_nxt = busy_r;
    k_nxt    = k_r;
    ov_nxt   = ov_r;
    od_nxt   = od_r;
    ol_nxt   = ol_r;
    of_nxt   = of_r;
    if (adv) begin
      ov_nxt = busy_r;
      if (busy_r) begin
        od_nxt = {wr, wc, cur_r.blue, cur_r.green, cur_r.red};
        ol_nxt = (k_r == k_last);
        of_nxt = (k_r == k_last) && cur_r.frame_end;
        if (k_r == k_last) begin
          busy_nxt = 1'b0;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
    end
    if (!busy_r && job_valid) begin
      cur_nxt  = job;
      busy_nxt = 1'b1;
      k_nxt    = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
    cur_r <= cur_nxt;
    k_r   <= k_nxt;
    od_r  <= od_nxt;
    ol_r  <= ol_nxt;
    of_r  <= of_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign out_last  = ol_r;
  assign out_fend  = of_r;

endmodule

[design/bayer_stretch_block_demosaic.sv]
// top level of the bayer contrast-stretch 2x2 block demosaic
//
// in_*  : one raw bayer sample per word, raster order, accepted on tvalid and tready
// out_* : rgb pixel words with their column and row; tlast marks the final word
//         caused by an input sample, tuser marks the last pixel of the frame
// cfg_* : register writes on cfg_we; user must write only while idle (unenforced)
// in_tready is high only while the front end is idle; after taking a sample it runs
// conversion, stretch, the serial divider (one quotient bit per cycle) when the
// contrast stretch needs it, the store reads and emit, which waits for queue room,
// and takes no new sample before emit; the twelve-bit reduction is combinational
// an input that completes a block gives four words, edge samples give one or two,
// most samples give none; words reach out_* via back end job and output registers
// the front end goes on with the next sample while the back end drains the
// job queue, so a stalled receiver holds words and later fills the queue
// before in_tready stays low
// reset clears counters, queue and output valid; registers go to defaults,
// line and block stores hold no defined data until a frame writes them
module bayer_stretch_block_demosaic
  import bsd_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // raw_sample
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,  // red, green, blue, out_column, out_row
  output logic              out_tlast,
  output logic              out_tuser,  // frame_end
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [DIM_W-1:0]  cfg_wdata
);

  cfg_t             cfg_r, cfg_nxt;
  logic             f_job_valid, q_push_ready, q_pop_valid, b_job_ready;
  job_t             f_job, q_job;
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:   cfg_nxt.frame_width   = cfg_wdata;
        REG_FRAME_HEIGHT:  cfg_nxt.frame_height  = cfg_wdata;
        REG_BAYER_PATTERN: cfg_nxt.bayer_pattern = cfg_wdata[1:0];
        REG_SAMPLE_FORMAT: cfg_nxt.sample_format = cfg_wdata[0];
        REG_STRETCH_LOW:   cfg_nxt.stretch_low   = cfg_wdata[PIX_W-1:0];
        REG_STRETCH_HIGH:  cfg_nxt.stretch_high  = cfg_wdata[PIX_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width   <= DIM_W'(640);
      cfg_r.frame_height  <= DIM_W'(480);
      cfg_r.bayer_pattern <= 2'd0;
      cfg_r.sample_format <= 1'b0;
      cfg_r.stretch_low   <= 8'd0;
      cfg_r.stretch_high  <= 8'd255;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bsd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_raw    (in_tdata),
    .job_valid (f_job_valid),
    .job_ready (q_push_ready),
    .job       (f_job),
    .div_start (div_start),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_done  (div_done),
    .div_quo   (div_quo)
  );

  bsd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  bsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_job_valid),
    .push_ready (q_push_ready),
    .push_job   (f_job),
    .pop_valid  (q_pop_valid),
    .pop_ready  (b_job_ready),
    .pop_job    (q_job)
  );

  bsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_pop_valid),
    .job_ready (b_job_ready),
    .job       (q_job),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast),
    .out_fend  (out_tuser)
  );

endmodule

[design/bsd_checker.sv]
// port-level checker for the demosaic block, bound to the top level
`include "assert_macros.svh"

module bsd_checker
  import bsd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [15:0]       in_tdata,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [47:0]       out_tdata,
  input logic              out_tlast,
  input logic              out_tuser,
  input logic              cfg_we,
  input logic [CFG_AW-1:0] cfg_addr,
  input logic [DIM_W-1:0]  cfg_wdata
);

  logic unused_ok;
  assign unused_ok = in_tvalid ^ in_tready ^ (^in_tdata) ^ (^out_tdata)
                   ^ cfg_we ^ (^cfg_addr) ^ (^cfg_wdata);

  `BSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "word dropped")
  `BSD_ASSERT_IMPL(a_fend_last, clk, rst_n, out_tvalid && out_tuser, out_tlast, "frame end not last")
  `BSD_ASSERT_ALWAYS_NEXT(a_rst_quiet, clk, !rst_n, !out_tvalid, "output valid after reset")

endmodule

bind bayer_stretch_block_demosaic bsd_checker u_bsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser),
  .cfg_we     (cfg_we),
  .cfg_addr   (cfg_addr),
  .cfg_wdata  (cfg_wdata)
);

[sim/bayer_stretch_block_demosaic_tb.sv]
// self-checking testbench for the bayer contrast-stretch 2x2 block demosaic
module bayer_stretch_block_demosaic_tb;
  import bsd_pkg::*;

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] col;
    logic [11:0] row;
    logic        last;
    logic        fe;
  } pixel_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [47:0]       out_tdata;
  logic              out_tlast;
  logic              out_tuser;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [DIM_W-1:0]  cfg_wdata = '0;

  bayer_stretch_block_demosaic u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [12:0] p_width = 13'd640, p_height = 13'd480;
  logic [1:0]  p_pattern = 2'd0;
  logic        p_format = 1'b0;
  logic [7:0]  p_low = 8'd0, p_high = 8'd255;
  int          col_cnt = 0, row_cnt = 0;
  logic [7:0]  upper_row [0:4095];
  logic [7:0]  left_px = '0;
  logic [23:0] block_rgb [0:2048];
  logic [23:0] last_rgb = '0;

  logic [15:0] pending_samples [$];
  pixel_t      expected_pixels [$];
  int          errors = 0;
  bit          no_idle = 1'b0;
  int          in_gap = 0, out_gap = 0;
  int          cycles = 0;
  int          random_items = 0;

  function automatic int draw_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] to_level(input logic [15:0] raw);
    int v;
    if (p_format) v = (int'(raw[11:0]) * 255 + 2047) / 4095;
    else v = int'(raw[7:0]);
    if (p_high > p_low) begin
      if (v <= int'(p_low)) v = 0;
      else begin
        v = (v - int'(p_low)) * 255 / (int'(p_high) - int'(p_low));
        if (v > 255) v = 255;
      end
    end
    return v[7:0];
  endfunction

  function automatic logic [1:0] slot_red(input logic [1:0] p);
    case (p)
      2'd0: return 2'd1;
      2'd1: return 2'd0;
      2'd2: return 2'd2;
      default: return 2'd3;
    endcase
  endfunction

  function automatic logic [1:0] slot_blue(input logic [1:0] p);
    case (p)
      2'd0: return 2'd2;
      2'd1: return 2'd3;
      2'd2: return 2'd1;
      default: return 2'd0;
    endcase
  endfunction

  task automatic demosaic_sample(input logic [15:0] raw);
    int w, h, col, row, n, g;
    logic [7:0] v;
    logic [7:0] blk [4];
    logic [23:0] rgb [4];
    int pc [4], pr [4];
    pixel_t px;
    w = int'(p_width);
    h = int'(p_height);
    if (w < 2) w = 2;
    if (w > 4096) w = 4096;
    if (h < 2) h = 2;
    if (h > 4096) h = 4096;
    if (col_cnt >= w || row_cnt >= h) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    col = col_cnt;
    row = row_cnt;
    v = to_level(raw);
    n = 0;
    if (row % 2 == 1) begin
      if (col % 2 == 1) begin
        blk[0] = upper_row[col-1];
        blk[1] = upper_row[col];
        blk[2] = left_px;
        blk[3] = v;
        g = (int'(blk[p_pattern[0] ? 1 : 0]) + int'(blk[p_pattern[0] ? 2 : 3]) + 1) / 2;
        last_rgb = {blk[slot_red(p_pattern)], g[7:0], blk[slot_blue(p_pattern)]};
        block_rgb[col/2] = last_rgb;
        for (int k = 0; k < 4; k++) begin
          rgb[k] = last_rgb;
          pc[k] = (k % 2 == 0) ? col - 1 : col;
          pr[k] = (k < 2) ? row - 1 : row;
        end
        n = 4;
      end else begin
        left_px = v;
        if (col == w - 1) begin
          rgb[0] = last_rgb; pc[0] = col; pr[0] = row - 1;
          rgb[1] = last_rgb; pc[1] = col; pr[1] = row;
          n = 2;
        end
      end
    end else if (row == h - 1) begin
      if (col % 2 == 1) begin
        rgb[0] = block_rgb[col/2]; pc[0] = col - 1; pr[0] = row;
        rgb[1] = block_rgb[col/2]; pc[1] = col; pr[1] = row;
        n = 2;
      end else if (col == w - 1) begin
        rgb[0] = block_rgb[(col-1)/2]; pc[0] = col; pr[0] = row;
        n = 1;
      end
    end else begin
      upper_row[col] = v;
    end
    for (int k = 0; k < n; k++) begin
      px.red = rgb[k][23:16];
      px.green = rgb[k][15:8];
      px.blue = rgb[k][7:0];
      px.col = pc[k][11:0];
      px.row = pr[k][11:0];
      px.last = (k == n - 1);
      px.fe = (k == n - 1) && row == h - 1 && col == w - 1;
      expected_pixels.push_back(px);
    end
    if (col + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) demosaic_sample(in_tdata);
      if (in_tvalid && !in_tready) begin
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        in_tdata <= pending_samples.pop_front();
        in_tvalid <= 1'b1;
        in_gap = draw_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pixel_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected word col %0d row %0d", out_tdata[35:24], out_tdata[47:36]);
          errors++;
        end else begin
          e = expected_pixels.pop_front();
          if (out_tdata[7:0] !== e.red) begin
            $error("red exp %0d got %0d", e.red, out_tdata[7:0]); errors++;
          end
          if (out_tdata[15:8] !== e.green) begin
            $error("green exp %0d got %0d", e.green, out_tdata[15:8]); errors++;
          end
          if (out_tdata[23:16] !== e.blue) begin
            $error("blue exp %0d got %0d", e.blue, out_tdata[23:16]); errors++;
          end
          if (out_tdata[35:24] !== e.col) begin
            $error("out_column exp %0d got %0d", e.col, out_tdata[35:24]); errors++;
          end
          if (out_tdata[47:36] !== e.row) begin
            $error("out_row exp %0d got %0d", e.row, out_tdata[47:36]); errors++;
          end
          if (out_tlast !== e.last) begin
            $error("last_in_run exp %0d got %0d", e.last, out_tlast); errors++;
          end
          if (out_tuser !== e.fe) begin
            $error("frame_end exp %0d got %0d", e.fe, out_tuser); errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_gap = draw_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("bayer_stretch_block_demosaic_tb failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() > 0 || in_tvalid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] a, input int d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= d[DIM_W-1:0];
    case (a)
      REG_FRAME_WIDTH:   p_width = d[12:0];
      REG_FRAME_HEIGHT:  p_height = d[12:0];
      REG_BAYER_PATTERN: p_pattern = d[1:0];
      REG_SAMPLE_FORMAT: p_format = d[0];
      REG_STRETCH_LOW:   p_low = d[7:0];
      default:           p_high = d[7:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup(input int w, input int h, input int pat, input int fmt,
                       input int lo, input int hi);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_BAYER_PATTERN, pat);
    write_reg(REG_SAMPLE_FORMAT, fmt);
    write_reg(REG_STRETCH_LOW, lo);
    write_reg(REG_STRETCH_HIGH, hi);
  endtask

  function automatic int frame_size();
    int w, h;
    w = int'(p_width); h = int'(p_height);
    if (w < 2) w = 2;
    if (w > 4096) w = 4096;
    if (h < 2) h = 2;
    if (h > 4096) h = 4096;
    return w * h;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return {4'($urandom), 12'hFFF};
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int n, w, h, lo, hi;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames
    setup(2, 2, 0, 0, 0, 255);
    pending_samples = '{16'h00FF, 16'h0000, 16'hFFFF, 16'h1234};
    setup(3, 3, 1, 1, 10, 200);
    pending_samples = '{16'h0FFF, 16'h0000, 16'hF000, 16'h0800, 16'h0001,
                        16'hFFFE, 16'h7FFF, 16'h8000, 16'h0ABC};
    setup(1, 0, 2, 0, 100, 100);
    pending_samples = '{16'h00FF, 16'h0064, 16'h0065, 16'h0000};
    setup(5, 2, 3, 0, 255, 0);
    for (int i = 0; i < 10; i++) pending_samples.push_back(rand_sample());

    // random frames, the first paused halfway until all words are out
    while (random_items < 270) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 7);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 5);
      lo = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 255);
      hi = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(0, 255);
      setup(w, h, $urandom_range(0, 3), $urandom_range(0, 1), lo, hi);
      no_idle = ($urandom_range(0, 4) == 0);
      n = frame_size();
      for (int i = 0; i < n; i++) begin
        pending_samples.push_back(rand_sample());
        if (random_items == 0 && i == n / 2) begin
          while (pending_samples.size() > 0 || in_tvalid || expected_pixels.size() > 0)
            @(posedge clk);
        end
      end
      random_items += n;
    end

    wait_drained();
    if (errors == 0) $display("bayer_stretch_block_demosaic_tb passed");
    else $display("bayer_stretch_block_demosaic_tb failed");
    $finish;
  end

endmodule
